/* rtl/ppsched_pkg.sv */
// shared types and constants of the preemptive priority request scheduler
// no dependencies; imported by ppsched_fifo and the top level
package ppsched_pkg;

  localparam int unsigned QUEUE_DEPTH = 8;
  localparam int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ID_W        = 16;
  localparam int unsigned NUM_FIFOS   = 3;

  // fifo slots in the per-queue control vectors
  localparam logic [1:0] Q_HIGHEST = 2'd0;
  localparam logic [1:0] Q_HIGH    = 2'd1;
  localparam logic [1:0] Q_NORMAL  = 2'd2;

  typedef enum logic {
    OP_SUBMIT = 1'b0,
    OP_TICK   = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    LVL_HIGHEST    = 2'd0,
    LVL_HIGH       = 2'd1,
    LVL_NORMAL     = 2'd2,
    LVL_BACKGROUND = 2'd3
  } level_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_IGNORED = 2'd1,
    ST_DROPPED = 2'd2
  } status_e;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

/* rtl/ppsched_fifo.sv */
// one request fifo of the scheduler: head and fill count with flop storage
// depends on ppsched_pkg
module ppsched_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  logic                         push_i,
  input  logic                         pop_i,
  input  logic [ppsched_pkg::ID_W-1:0] data_i,
  output logic [ppsched_pkg::ID_W-1:0] data_o,
  output ppsched_pkg::fifo_stat_t      stat_o
);
  import ppsched_pkg::*;

  logic [ID_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [IDX_W-1:0] head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;
  logic             full, empty;
  logic             do_push, do_pop;

  assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = push_i && !full && !clr_i;
  assign do_pop  = pop_i && !empty && !clr_i;

  // head + count wraps at most once
  always_comb begin
    tail_sum = (IDX_W+1)'(head_q) + (IDX_W+1)'(count_q);
    if (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (IDX_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    if (clr_i) begin
      head_d  = '0;
      count_d = '0;
    end else begin
      if (do_pop) begin
        head_d  = (head_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
        count_d = count_q - 1'b1;
      end
      if (do_push) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[tail] <= data_i;
    end
  end

  assign data_o       = mem_q[head_q];
  assign stat_o.full  = full;
  assign stat_o.empty = empty;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("fifo fill count beyond depth");

  a_clr_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_i |=> empty)
    else $error("fifo not empty after clear");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full && !clr_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("fifo push lost");

endmodule

/* rtl/preemptive_priority_request_scheduler.sv */
// preemptive four-level request scheduler, top level
// depends on ppsched_pkg and ppsched_fifo
//
// usage:
//   an item is taken at a rising edge with start_i high and busy_o low; busy_o
//   stays low, so an item may be issued in every cycle
//   opcode_i selects submit (prio_i, request_id_i) or tick (all_done_i)
//   each item yields exactly one result, shown for one cycle with
//   result_valid_o high; the receiver cannot stall, results must be taken
//   latency: 2 cycles from the accepting edge to the edge that takes the
//   result (input register, then scheduling logic into the result register)
//   throughput: 1 item per cycle; every item touches only fifo heads/tails,
//   the background slot and a 3-way priority pick, so state is read and
//   updated within the one cycle an item spends in the work stage
//   reset: all fifos empty, background slot empty, active level background,
//   idle set, no result pending
//   levels: 0 highest, 1 high, 2 normal (8-deep fifos), 3 background (one
//   slot, overwritten by each background submit and re-dispatched on every
//   finished tick while all fifos are empty)
module preemptive_priority_request_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        opcode_i,
  input  logic [1:0]  prio_i,
  input  logic [15:0] request_id_i,
  input  logic        all_done_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic        cancel_o,
  output logic        dispatch_valid_o,
  output logic [15:0] dispatch_id_o,
  output logic [1:0]  active_level_o,
  output logic        idle_o
);
  import ppsched_pkg::*;

  // input register
  logic            in_vld_q;
  opcode_e         opcode_q;
  level_e          prio_q;
  logic [ID_W-1:0] rid_q;
  logic            all_done_q;

  // scheduler state
  level_e          act_q, act_d;
  logic            idle_q, idle_d;
  logic            bg_vld_q, bg_vld_d;
  logic [ID_W-1:0] bg_id_q, bg_id_d;

  // fifo controls and status
  logic [NUM_FIFOS-1:0] fifo_clr, fifo_push, fifo_pop;
  logic [ID_W-1:0]      fifo_head [NUM_FIFOS];
  fifo_stat_t           fifo_stat [NUM_FIFOS];

  // result register
  logic            res_vld_q;
  status_e         status_q, status_d;
  logic            cancel_q, cancel_d;
  logic            dvld_q, dvld_d;
  logic [ID_W-1:0] did_q, did_d;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      opcode_q   <= opcode_e'(opcode_i);
      prio_q     <= level_e'(prio_i);
      rid_q      <= request_id_i;
      all_done_q <= all_done_i;
    end
  end

  for (genvar g = 0; g < NUM_FIFOS; g++) begin : g_fifo
    ppsched_fifo u_fifo (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .clr_i  (fifo_clr[g]),
      .push_i (fifo_push[g]),
      .pop_i  (fifo_pop[g]),
      .data_i (rid_q),
      .data_o (fifo_head[g]),
      .stat_o (fifo_stat[g])
    );
  end

  // one item per cycle: submit rules or tick dispatch
  always_comb begin
    fifo_clr  = '0;
    fifo_push = '0;
    fifo_pop  = '0;
    act_d     = act_q;
    idle_d    = idle_q;
    bg_vld_d  = bg_vld_q;
    bg_id_d   = bg_id_q;
    status_d  = ST_OK;
    cancel_d  = 1'b0;
    dvld_d    = 1'b0;
    did_d     = '0;
    if (in_vld_q) begin
      if (opcode_q == OP_SUBMIT) begin
        case (prio_q)
          LVL_HIGHEST: begin
            // preempt everything below and drop the background slot
            fifo_clr[Q_HIGH]      = 1'b1;
            fifo_clr[Q_NORMAL]    = 1'b1;
            bg_vld_d              = 1'b0;
            bg_id_d               = '0;
            cancel_d              = 1'b1;
            fifo_push[Q_HIGHEST]  = 1'b1;
            if (fifo_stat[Q_HIGHEST].full) status_d = ST_DROPPED;
          end
          LVL_HIGH: begin
            if (act_q == LVL_HIGHEST) begin
              status_d = ST_IGNORED;
            end else begin
              cancel_d          = (act_q != LVL_HIGH);
              fifo_push[Q_HIGH] = 1'b1;
              if (fifo_stat[Q_HIGH].full) status_d = ST_DROPPED;
            end
          end
          LVL_NORMAL: begin
            if (act_q == LVL_HIGHEST) begin
              status_d = ST_IGNORED;
            end else begin
              fifo_push[Q_NORMAL] = 1'b1;
              if (fifo_stat[Q_NORMAL].full) status_d = ST_DROPPED;
            end
          end
          default: begin
            if (act_q == LVL_HIGHEST) begin
              status_d = ST_IGNORED;
            end else begin
              bg_vld_d = 1'b1;
              bg_id_d  = rid_q;
            end
          end
        endcase
      end else begin
        idle_d = all_done_q;
        if (all_done_q) begin
          // pick the highest non-empty fifo, else fall back to background
          if (!fifo_stat[Q_HIGHEST].empty) begin
            fifo_pop[Q_HIGHEST] = 1'b1;
            did_d               = fifo_head[Q_HIGHEST];
            dvld_d              = 1'b1;
            act_d               = LVL_HIGHEST;
          end else if (!fifo_stat[Q_HIGH].empty) begin
            fifo_pop[Q_HIGH] = 1'b1;
            did_d            = fifo_head[Q_HIGH];
            dvld_d           = 1'b1;
            act_d            = LVL_HIGH;
          end else if (!fifo_stat[Q_NORMAL].empty) begin
            fifo_pop[Q_NORMAL] = 1'b1;
            did_d              = fifo_head[Q_NORMAL];
            dvld_d             = 1'b1;
            act_d              = LVL_NORMAL;
          end else begin
            act_d = LVL_BACKGROUND;
            if (bg_vld_q) begin
              dvld_d = 1'b1;
              did_d  = bg_id_q;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q     <= LVL_BACKGROUND;
      idle_q    <= 1'b1;
      bg_vld_q  <= 1'b0;
      bg_id_q   <= '0;
      res_vld_q <= 1'b0;
    end else begin
      act_q     <= act_d;
      idle_q    <= idle_d;
      bg_vld_q  <= bg_vld_d;
      bg_id_q   <= bg_id_d;
      res_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      status_q <= status_d;
      cancel_q <= cancel_d;
      dvld_q   <= dvld_d;
      did_q    <= did_d;
    end
  end

  assign result_valid_o   = res_vld_q;
  assign status_o         = status_q;
  assign cancel_o         = cancel_q;
  assign dispatch_valid_o = dvld_q;
  assign dispatch_id_o    = did_q;
  assign active_level_o   = act_q;
  assign idle_o           = idle_q;

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> ##1 result_valid_o)
    else $error("accepted item produced no result");

  a_cancel_not_ignored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && cancel_o) |-> (status_o != ST_IGNORED) && !dispatch_valid_o)
    else $error("cancel pulsed on an ignored submit or a tick");

  a_dispatch_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && dispatch_valid_o) |-> idle_o && (status_o == ST_OK))
    else $error("dispatch without finished tick");

  a_no_pop_on_submit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && opcode_q == OP_SUBMIT) |-> (fifo_pop == '0))
    else $error("fifo popped on a submit");

  a_single_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(fifo_pop))
    else $error("more than one fifo popped");

endmodule
